### sv/tif_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the telnet IAC filter and negotiator.
// Depends on nothing; every other file of the block imports it.
package tif_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned RegW  = 64;
  localparam int unsigned MapW  = 256;
  localparam int unsigned IdxW  = 3;

  // Telnet command codes.
  localparam logic [ByteW-1:0] TN_IAC  = 8'd255;
  localparam logic [ByteW-1:0] TN_DONT = 8'd254;
  localparam logic [ByteW-1:0] TN_DO   = 8'd253;
  localparam logic [ByteW-1:0] TN_WONT = 8'd252;
  localparam logic [ByteW-1:0] TN_WILL = 8'd251;
  localparam logic [ByteW-1:0] TN_SB   = 8'd250;
  localparam logic [ByteW-1:0] TN_SE   = 8'd240;

  // Received negotiation verb, stored as command minus WILL.
  localparam logic [1:0] VERB_WILL = 2'd0;
  localparam logic [1:0] VERB_DO   = 2'd2;

  // Result kinds.
  localparam logic KIND_DATA  = 1'b0;
  localparam logic KIND_REPLY = 1'b1;

  // Reset values of the accept maps (options 1 and 3 remote, option 3 local).
  localparam logic [MapW-1:0] REMOTE_RST = 256'd10;
  localparam logic [MapW-1:0] LOCAL_RST  = 256'd8;

  typedef enum logic [4:0] {
    PH_DATA    = 5'b00001,
    PH_IAC     = 5'b00010,
    PH_OPT     = 5'b00100,
    PH_SUB     = 5'b01000,
    PH_SUB_IAC = 5'b10000
  } phase_t;

  // Accept map bits for the option byte currently being parsed.
  typedef struct packed {
    logic remote;
    logic local_ok;
  } hit_t;

  typedef struct packed {
    logic             kind;
    logic [ByteW-1:0] data_byte;
    logic [ByteW-1:0] reply_command;
    logic [ByteW-1:0] reply_option;
  } result_t;

endpackage

### sv/tif_cfg.sv
`timescale 1ns / 1ps
// Accept map registers for both negotiation directions and the bit lookup.
// Depends on tif_pkg.
module tif_cfg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [tif_pkg::IdxW-1:0]     cfg_index,
  input  logic [tif_pkg::RegW-1:0]     cfg_data,
  input  logic [tif_pkg::ByteW-1:0]    opt_byte,
  output tif_pkg::hit_t                hit
);
  import tif_pkg::*;

  logic [MapW-1:0] remote_map_r, remote_map_nxt;
  logic [MapW-1:0] local_map_r, local_map_nxt;

  always_comb begin
    remote_map_nxt = remote_map_r;
    local_map_nxt  = local_map_r;
    if (cfg_we) begin
      // The top index bit picks the direction, the low bits the 64-bit slice.
      if (cfg_index[IdxW-1]) begin
        local_map_nxt[{cfg_index[IdxW-2:0], 6'd0} +: RegW] = cfg_data;
      end else begin
        remote_map_nxt[{cfg_index[IdxW-2:0], 6'd0} +: RegW] = cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      remote_map_r <= REMOTE_RST;
      local_map_r  <= LOCAL_RST;
    end else begin
      remote_map_r <= remote_map_nxt;
      local_map_r  <= local_map_nxt;
    end
  end

  assign hit.remote   = remote_map_r[opt_byte];
  assign hit.local_ok = local_map_r[opt_byte];

endmodule

### sv/tif_parse.sv
`timescale 1ns / 1ps
// Input byte register and the telnet parse state machine that turns one
// byte into at most one result. Depends on tif_pkg.
module tif_parse (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [tif_pkg::ByteW-1:0]    in_rx_byte,
  output logic [tif_pkg::ByteW-1:0]    opt_byte,
  input  tif_pkg::hit_t                hit,
  input  logic                         res_ready,
  output logic                         res_valid,
  output tif_pkg::result_t             res
);
  import tif_pkg::*;

  logic             s1_vld_r, s1_vld_nxt;
  logic [ByteW-1:0] s1_byte_r;
  phase_t           phase_r, phase_nxt;
  logic [1:0]       verb_r, verb_nxt;
  phase_t           phase_new;
  logic [1:0]       verb_new;
  logic             has_res;
  logic             s1_go;
  logic             in_take;
  logic [ByteW-1:0] b;

  assign b        = s1_byte_r;
  assign opt_byte = s1_byte_r;

  always_comb begin
    phase_new         = PH_DATA;
    verb_new          = verb_r;
    has_res           = 1'b0;
    res.kind          = KIND_DATA;
    res.data_byte     = '0;
    res.reply_command = '0;
    res.reply_option  = '0;
    unique case (phase_r)
      PH_IAC: begin
        if (b == TN_IAC) begin
          has_res       = 1'b1;
          res.data_byte = TN_IAC;
        end else if (b >= TN_WILL) begin
          verb_new  = 2'(b - TN_WILL);
          phase_new = PH_OPT;
        end else if (b == TN_SB) begin
          phase_new = PH_SUB;
        end
      end
      PH_OPT: begin
        // WONT and DONT fall through with no reply.
        if (verb_r == VERB_WILL) begin
          has_res           = 1'b1;
          res.kind          = KIND_REPLY;
          res.reply_command = hit.remote ? TN_DO : TN_DONT;
          res.reply_option  = b;
        end else if (verb_r == VERB_DO) begin
          has_res           = 1'b1;
          res.kind          = KIND_REPLY;
          res.reply_command = hit.local_ok ? TN_WILL : TN_WONT;
          res.reply_option  = b;
        end
      end
      PH_SUB: begin
        phase_new = (b == TN_IAC) ? PH_SUB_IAC : PH_SUB;
      end
      PH_SUB_IAC: begin
        phase_new = (b == TN_SE) ? PH_DATA : PH_SUB;
      end
      default: begin
        if (b == TN_IAC) begin
          phase_new = PH_IAC;
        end else begin
          has_res       = 1'b1;
          res.data_byte = b;
        end
      end
    endcase
  end

  // A byte that yields nothing leaves the stage even when the output is full.
  assign s1_go     = s1_vld_r && (res_ready || !has_res);
  assign res_valid = s1_go && has_res;
  assign in_stall  = s1_vld_r && !s1_go;
  assign in_take   = in_valid && !in_stall;

  always_comb begin
    phase_nxt  = s1_go ? phase_new : phase_r;
    verb_nxt   = s1_go ? verb_new : verb_r;
    s1_vld_nxt = in_take || (s1_vld_r && !s1_go);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      phase_r  <= PH_DATA;
      verb_r   <= 2'd0;
    end else begin
      s1_vld_r <= s1_vld_nxt;
      phase_r  <= phase_nxt;
      verb_r   <= verb_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte_r <= in_rx_byte;
    end
  end

endmodule

### sv/telnet_iac_filter_negotiator.sv
`timescale 1ns / 1ps
// Telnet receive filter: strips IAC sequences and answers WILL/DO requests.
// Depends on tif_pkg, tif_cfg and tif_parse.
//
// Usage:
//   Input channel in_valid / in_stall / in_rx_byte carries one received byte
//   per beat. Output channel out_valid / out_stall carries one result per
//   beat: a user data byte (out_kind 0) or a reply to send as IAC cmd opt
//   (out_kind 1). Bytes that only advance the parser give no output beat.
//   The accept maps are written through cfg_we / cfg_index / cfg_data while
//   no byte is in flight; index 0..3 is the remote map, 4..7 the local map.
// Timing:
//   A byte accepted into the input register is parsed there and its result is
//   loaded into the output register once that register can take it. One byte
//   per cycle is sustained while the output does not stall: the parse state
//   (phase and verb registers) is updated from the current byte in one step.
// Reset (rst_n low, synchronous): parser back to plain data, pipeline empty,
//   accept maps back to options 1 and 3 remote and option 3 local.
// Stall: while out_stall holds a waiting result, one more byte may sit in
//   the input register; in_stall rises only if that byte also has a result.
module telnet_iac_filter_negotiator (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [tif_pkg::ByteW-1:0]    in_rx_byte,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_kind,
  output logic [tif_pkg::ByteW-1:0]    out_data_byte,
  output logic [tif_pkg::ByteW-1:0]    out_reply_command,
  output logic [tif_pkg::ByteW-1:0]    out_reply_option,
  input  logic                         cfg_we,
  input  logic [tif_pkg::IdxW-1:0]     cfg_index,
  input  logic [tif_pkg::RegW-1:0]     cfg_data
);
  import tif_pkg::*;

  hit_t             hit;
  logic [ByteW-1:0] opt_byte;
  logic             res_ready;
  logic             res_valid;
  result_t          res;
  logic             out_vld_r, out_vld_nxt;
  result_t          out_res_r;

  tif_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .opt_byte  (opt_byte),
    .hit       (hit)
  );

  tif_parse u_parse (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_rx_byte (in_rx_byte),
    .opt_byte   (opt_byte),
    .hit        (hit),
    .res_ready  (res_ready),
    .res_valid  (res_valid),
    .res        (res)
  );

  assign res_ready = !out_vld_r || !out_stall;

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (res_valid) begin
      out_vld_nxt = 1'b1;
    end else if (!out_stall) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_valid         = out_vld_r;
  assign out_kind          = out_res_r.kind;
  assign out_data_byte     = out_res_r.data_byte;
  assign out_reply_command = out_res_r.reply_command;
  assign out_reply_option  = out_res_r.reply_option;

endmodule

### test/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for the telnet IAC filter and negotiator: directed and
// random byte streams against an in-bench parser. Depends on tif_pkg and the top.
module testbench;
  import tif_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int DRAIN_LIMIT   = 5000;
  localparam int SETTLE_CYCLES = 4;
  localparam int PRINT_LIMIT   = 40;

  localparam logic [IdxW-1:0] REG_REMOTE_0 = 3'd0;
  localparam logic [IdxW-1:0] REG_LOCAL_0  = 3'd4;

  localparam logic [ByteW-1:0] OPENING_BYTES [30] = '{
    8'h00, 8'hFE,
    TN_IAC, TN_IAC,
    TN_IAC, TN_WILL, 8'd1,
    TN_IAC, TN_WILL, 8'd255,
    TN_IAC, TN_DO, 8'd3,
    TN_IAC, TN_DO, 8'd0,
    TN_IAC, TN_WONT, 8'd5,
    TN_IAC, TN_DONT, 8'd7,
    TN_IAC, TN_SB, TN_IAC, TN_IAC, TN_IAC, TN_SE,
    TN_IAC, TN_SE
  };

  logic             clk;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [ByteW-1:0] in_rx_byte = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic             out_kind;
  logic [ByteW-1:0] out_data_byte;
  logic [ByteW-1:0] out_reply_command;
  logic [ByteW-1:0] out_reply_option;
  logic             cfg_we = 1'b0;
  logic [IdxW-1:0]  cfg_index = '0;
  logic [RegW-1:0]  cfg_data = '0;

  // Parser state and accept maps as the block should hold them.
  phase_t          rx_phase = PH_DATA;
  logic [1:0]      rx_verb = 2'd0;
  logic [MapW-1:0] remote_map = REMOTE_RST;
  logic [MapW-1:0] local_map = LOCAL_RST;
  result_t         decoded_q [$];

  int feed_idle_pct = 0;
  int drain_idle_pct = 0;
  int hold_req = 0;
  int hold_left = 0;
  int cycle_count = 0;
  int error_count = 0;
  int bytes_sent = 0;
  int data_seen = 0;
  int replies_seen = 0;
  int input_stalls = 0;

  telnet_iac_filter_negotiator dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_kind          (out_kind),
    .out_data_byte     (out_data_byte),
    .out_reply_command (out_reply_command),
    .out_reply_option  (out_reply_option),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  task automatic report_mismatch(input string what);
    if (error_count < PRINT_LIMIT) begin
      $display("[%0t] mismatch: %s", $realtime, what);
    end
    error_count++;
  endtask

  // Advances the parser by one received byte and queues the beat it yields.
  task automatic parse_rx_byte(input logic [ByteW-1:0] b);
    result_t r;
    logic    yields;
    r = '0;
    yields = 1'b0;
    case (rx_phase)
      PH_IAC: begin
        if (b == TN_IAC) begin
          rx_phase = PH_DATA;
          r.kind = KIND_DATA;
          r.data_byte = TN_IAC;
          yields = 1'b1;
        end else if (b >= TN_WILL) begin
          rx_verb = 2'(b - TN_WILL);
          rx_phase = PH_OPT;
        end else if (b == TN_SB) begin
          rx_phase = PH_SUB;
        end else begin
          rx_phase = PH_DATA;
        end
      end
      PH_OPT: begin
        rx_phase = PH_DATA;
        r.kind = KIND_REPLY;
        r.reply_option = b;
        if (rx_verb == VERB_WILL) begin
          r.reply_command = remote_map[b] ? TN_DO : TN_DONT;
          yields = 1'b1;
        end else if (rx_verb == VERB_DO) begin
          r.reply_command = local_map[b] ? TN_WILL : TN_WONT;
          yields = 1'b1;
        end
      end
      PH_SUB: begin
        if (b == TN_IAC) rx_phase = PH_SUB_IAC;
      end
      PH_SUB_IAC: begin
        rx_phase = (b == TN_SE) ? PH_DATA : PH_SUB;
      end
      default: begin
        rx_phase = PH_DATA;
        if (b == TN_IAC) begin
          rx_phase = PH_IAC;
        end else begin
          r.kind = KIND_DATA;
          r.data_byte = b;
          yields = 1'b1;
        end
      end
    endcase
    if (yields) decoded_q = {decoded_q, r};
  endtask

  // Called at a falling edge; returns at the falling edge after the beat.
  task automatic send_byte(input logic [ByteW-1:0] b);
    // Each cycle the sender idles with the chance given by feed_idle_pct.
    while ($urandom_range(99) < feed_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_stall !== 1'b0) begin
      input_stalls++;
      @(posedge clk);
    end
    parse_rx_byte(b);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    int waited;
    in_valid <= 1'b0;
    waited = 0;
    while (decoded_q.size() != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    if (decoded_q.size() != 0) begin
      report_mismatch($sformatf("%0d result beats never arrived", decoded_q.size()));
      decoded_q.delete();
    end
    // Bytes that give no beat may still sit in the pipeline.
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_maps(input logic [MapW-1:0] rmap, input logic [MapW-1:0] lmap);
    for (int i = 0; i < 8; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= (i < 4) ? REG_REMOTE_0 + IdxW'(i) : REG_LOCAL_0 + IdxW'(i - 4);
      cfg_data <= (i < 4) ? rmap[i*RegW +: RegW] : lmap[(i-4)*RegW +: RegW];
      @(negedge clk);
    end
    cfg_we <= 1'b0;
    remote_map = rmap;
    local_map = lmap;
  endtask

  // The sender and receiver read these at falling edges, so change them at a rising one.
  task automatic set_idling(input int feed_pct, input int drain_pct);
    @(posedge clk);
    feed_idle_pct = feed_pct;
    drain_idle_pct = drain_pct;
    @(negedge clk);
  endtask

  function automatic logic [MapW-1:0] rand_map();
    logic [MapW-1:0] m;
    for (int i = 0; i < MapW / 32; i++) m[i*32 +: 32] = $urandom;
    return m;
  endfunction

  task automatic test_directed();
    foreach (OPENING_BYTES[i]) send_byte(OPENING_BYTES[i]);
    wait_idle();
  endtask

  // Mostly well-formed telnet sequences with random content, plus raw noise.
  task automatic test_random_traffic(input int n_bytes);
    int start;
    int pick;
    int len;
    start = bytes_sent;
    while (bytes_sent - start < n_bytes) begin
      pick = $urandom_range(99);
      if (pick < 35) begin
        send_byte(ByteW'($urandom_range(0, 254)));
      end else if (pick < 43) begin
        send_byte(TN_IAC);
        send_byte(TN_IAC);
      end else if (pick < 73) begin
        send_byte(TN_IAC);
        send_byte($urandom_range(1) ? TN_WILL : TN_DO);
        send_byte(ByteW'($urandom_range(0, 255)));
      end else if (pick < 80) begin
        send_byte(TN_IAC);
        send_byte($urandom_range(1) ? TN_WONT : TN_DONT);
        send_byte(ByteW'($urandom_range(0, 255)));
      end else if (pick < 90) begin
        send_byte(TN_IAC);
        send_byte(TN_SB);
        len = $urandom_range(0, 5);
        repeat (len) send_byte(ByteW'($urandom_range(0, 255)));
        send_byte(TN_IAC);
        send_byte(TN_SE);
      end else if (pick < 95) begin
        send_byte(TN_IAC);
        send_byte(ByteW'($urandom_range(0, 249)));
      end else begin
        send_byte(ByteW'($urandom_range(0, 255)));
      end
    end
    wait_idle();
  endtask

  // Receiver holds off for a long stretch while plain data keeps coming in.
  task automatic test_backpressure();
    @(posedge clk);
    hold_req = 80;
    @(negedge clk);
    repeat (40) send_byte(ByteW'($urandom_range(0, 254)));
    wait_idle();
  endtask

  // Sender stops until the block has delivered everything, then resumes.
  task automatic test_drain_pause();
    repeat (20) send_byte(ByteW'($urandom_range(0, 255)));
    wait_idle();
    repeat (20) send_byte(ByteW'($urandom_range(0, 255)));
    wait_idle();
  endtask

  always @(negedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < drain_idle_pct);
    end
  end

  always @(posedge clk) begin
    result_t want;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles", cycle_count);
      $display("FAIL");
      $finish;
    end else if (rst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
      if (decoded_q.size() == 0) begin
        report_mismatch($sformatf("unexpected beat kind %0d data %0d cmd %0d opt %0d",
                                  out_kind, out_data_byte, out_reply_command,
                                  out_reply_option));
      end else begin
        want = decoded_q.pop_front();
        if (out_kind !== want.kind)
          report_mismatch($sformatf("kind %0d, want %0d", out_kind, want.kind));
        if (out_data_byte !== want.data_byte)
          report_mismatch($sformatf("data_byte %0d, want %0d", out_data_byte,
                                    want.data_byte));
        if (out_reply_command !== want.reply_command)
          report_mismatch($sformatf("reply_command %0d, want %0d", out_reply_command,
                                    want.reply_command));
        if (out_reply_option !== want.reply_option)
          report_mismatch($sformatf("reply_option %0d, want %0d", out_reply_option,
                                    want.reply_option));
        if (want.kind == KIND_REPLY) replies_seen++;
        else data_seen++;
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed();

    write_maps(rand_map(), rand_map());
    set_idling(35, 83);
    test_random_traffic(450);

    write_maps('1, '0);
    set_idling(83, 35);
    test_random_traffic(450);

    write_maps('0, '1);
    set_idling(0, 0);
    test_random_traffic(450);

    write_maps(rand_map(), rand_map());
    test_backpressure();
    test_drain_pause();

    $display("Sent %0d bytes under reset, random, all-set and all-clear accept maps;",
             bytes_sent);
    $display("checked %0d data beats and %0d replies, input held off %0d cycles, %0d errors.",
             data_seen, replies_seen, input_stalls, error_count);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
